>>> hw/rtl/lprf_pkg.sv
// shared constants and types for the length-prefixed record fifo
`default_nettype none
package lprf_pkg;

  localparam int BUFFER_BYTES = 1024;
  localparam int HEADER_BYTES = 4;
  localparam int MAX_RECORD   = 64;

  localparam int PTR_W  = $clog2(BUFFER_BYTES);
  localparam int FREE_W = PTR_W + 1;
  localparam int LEN_W  = 7;
  localparam int HDR_W  = 8 * HEADER_BYTES;
  localparam int HCNT_W = (HEADER_BYTES > 1) ? $clog2(HEADER_BYTES) : 1;

  localparam logic [1:0] OP_PUSH_START = 2'd0;
  localparam logic [1:0] OP_PUSH_BYTE  = 2'd1;
  localparam logic [1:0] OP_POP        = 2'd2;
  localparam logic [1:0] OP_FLUSH      = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_SEQ   = 2'd3;

  // commands from the controller to the datapath
  typedef struct packed {
    logic       load;
    logic       push_begin;
    logic       hdr_write;
    logic       byte_write;
    logic       flush;
    logic       hdr_read;
    logic       calc;
    logic       stream_read;
    logic       emit;
    logic [1:0] emit_status;
    logic       emit_byte;
    logic       emit_last;
  } lprf_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic [1:0] op;
    logic       push_open;
    logic       start_bad;
    logic       empty;
    logic       hcnt_last;
    logic       count_zero;
    logic       cnt_last;
  } lprf_stat_t;

endpackage
`default_nettype wire

>>> hw/rtl/length_prefixed_record_fifo.sv
// Variable-length record fifo over a circular byte store, each record led by
// a length header written least significant byte first. A command is taken
// when start is high and busy is low; each result appears for one cycle on
// result_valid and cannot be held off. The store has one write and one read
// port, one byte per cycle, which sets the timing: push_byte, flush and any
// refused or rejected command keep busy high for 1 cycle, an accepted
// push_start writes the header byte by byte, and a pop reads the header, then
// streams the record's bytes one per cycle, back to back. Each result is
// registered and shows in the cycle after its work is done.
`default_nettype none
module length_prefixed_record_fifo
  import lprf_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [1:0]        opcode,
  input  wire logic [LEN_W-1:0]  record_length,
  input  wire logic [7:0]        data_byte,
  output logic                   result_valid,
  output logic [1:0]             status,
  output logic [7:0]             out_byte,
  output logic                   byte_valid,
  output logic                   last,
  output logic [FREE_W-1:0]      free_bytes,
  output logic                   queue_empty
);

  lprf_cmd_t  cmd;
  lprf_stat_t stat;

  lprf_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  lprf_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .opcode        (opcode),
    .record_length (record_length),
    .data_byte     (data_byte),
    .cmd           (cmd),
    .stat          (stat),
    .status        (status),
    .out_byte      (out_byte),
    .byte_valid    (byte_valid),
    .last          (last),
    .free_bytes    (free_bytes),
    .queue_empty   (queue_empty),
    .result_valid  (result_valid)
  );

endmodule
`default_nettype wire

>>> hw/rtl/lprf_ctrl.sv
// controller state machine for the length-prefixed record fifo
`default_nettype none
module lprf_ctrl
  import lprf_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       start,
  input  wire lprf_stat_t stat,
  output lprf_cmd_t       cmd,
  output logic            busy
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECIDE = 3'd1;
  localparam logic [2:0] S_HWR    = 3'd2;
  localparam logic [2:0] S_HRD    = 3'd3;
  localparam logic [2:0] S_HWAIT  = 3'd4;
  localparam logic [2:0] S_CALC   = 3'd5;
  localparam logic [2:0] S_STREAM = 3'd6;

  logic [2:0] state;
  logic [2:0] state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.emit_last = 1'b1;
    case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_next = S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_next = S_IDLE;
        case (stat.op)
          OP_PUSH_START: begin
            if (stat.push_open) begin
              cmd.emit = 1'b1;
              cmd.emit_status = ST_SEQ;
            end else if (stat.start_bad) begin
              cmd.emit = 1'b1;
              cmd.emit_status = ST_FULL;
            end else begin
              cmd.push_begin = 1'b1;
              state_next = S_HWR;
            end
          end
          OP_PUSH_BYTE: begin
            cmd.emit = 1'b1;
            if (!stat.push_open) begin
              cmd.emit_status = ST_SEQ;
            end else begin
              cmd.byte_write = 1'b1;
              cmd.emit_status = ST_OK;
            end
          end
          OP_POP: begin
            if (stat.push_open) begin
              cmd.emit = 1'b1;
              cmd.emit_status = ST_SEQ;
            end else if (stat.empty) begin
              cmd.emit = 1'b1;
              cmd.emit_status = ST_EMPTY;
            end else begin
              state_next = S_HRD;
            end
          end
          OP_FLUSH: begin
            cmd.emit = 1'b1;
            if (stat.push_open) begin
              cmd.emit_status = ST_SEQ;
            end else begin
              cmd.flush = 1'b1;
              cmd.emit_status = ST_OK;
            end
          end
          default: begin
            cmd.emit = 1'b1;
            cmd.emit_status = ST_SEQ;
          end
        endcase
      end
      S_HWR: begin
        cmd.hdr_write = 1'b1;
        if (stat.hcnt_last) begin
          cmd.emit = 1'b1;
          cmd.emit_status = ST_OK;
          state_next = S_IDLE;
        end
      end
      S_HRD: begin
        cmd.hdr_read = 1'b1;
        if (stat.hcnt_last) begin
          state_next = S_HWAIT;
        end
      end
      S_HWAIT: begin
        // last header byte lands in the datapath this cycle
        state_next = S_CALC;
      end
      S_CALC: begin
        cmd.calc = 1'b1;
        if (stat.count_zero) begin
          cmd.emit = 1'b1;
          cmd.emit_status = ST_OK;
          state_next = S_IDLE;
        end else begin
          state_next = S_STREAM;
        end
      end
      S_STREAM: begin
        cmd.stream_read = 1'b1;
        cmd.emit = 1'b1;
        cmd.emit_status = ST_OK;
        cmd.emit_byte = 1'b1;
        cmd.emit_last = stat.cnt_last;
        if (stat.cnt_last) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

>>> hw/rtl/lprf_dp.sv
// datapath of the length-prefixed record fifo: byte store, pointers, counters
`default_nettype none
module lprf_dp
  import lprf_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic [1:0]        opcode,
  input  wire logic [LEN_W-1:0]  record_length,
  input  wire logic [7:0]        data_byte,
  input  wire lprf_cmd_t         cmd,
  output lprf_stat_t             stat,
  output logic [1:0]             status,
  output logic [7:0]             out_byte,
  output logic                   byte_valid,
  output logic                   last,
  output logic [FREE_W-1:0]      free_bytes,
  output logic                   queue_empty,
  output logic                   result_valid
);

  logic [7:0] mem [BUFFER_BYTES];
  logic [7:0] rdata;

  logic [1:0]        op;
  logic [LEN_W-1:0]  len;
  logic [7:0]        dbyte;
  logic [PTR_W-1:0]  rp;
  logic [PTR_W-1:0]  wp;
  logic [PTR_W-1:0]  sp;
  logic [FREE_W-1:0] free_count;
  logic [LEN_W-1:0]  push_rem;
  logic [HCNT_W-1:0] hcnt;
  logic [HDR_W-1:0]  hdr;
  logic              cap;
  logic [LEN_W-1:0]  cnt;

  logic [1:0] status_q;
  logic       byte_valid_q;
  logic       last_q;
  logic       result_valid_q;

  logic [HDR_W-1:0]  len_ext;
  logic [7:0]        hdr_byte;
  logic              we;
  logic [7:0]        wdata;
  logic              re;
  logic [PTR_W-1:0]  raddr;
  logic [PTR_W-1:0]  stored_lo;
  logic              stored_hi;
  logic              stored_gt_len;
  logic [PTR_W-1:0]  pick;
  logic [LEN_W-1:0]  count;
  logic [FREE_W:0]   free_sum;
  logic [FREE_W-1:0] free_after_pop;
  logic [FREE_W:0]   need;

  assign len_ext  = HDR_W'(len);
  assign hdr_byte = len_ext[8*hcnt +: 8];
  assign we       = cmd.hdr_write | cmd.byte_write;
  assign wdata    = cmd.hdr_write ? hdr_byte : dbyte;
  assign re       = cmd.hdr_read | cmd.stream_read;
  assign raddr    = cmd.stream_read ? sp : rp;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wp] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  // header length split into the part that moves the pointer and an overflow flag
  assign stored_lo     = hdr[PTR_W-1:0];
  assign stored_hi     = |hdr[HDR_W-1:PTR_W];
  assign stored_gt_len = stored_hi || (stored_lo > PTR_W'(len));
  assign pick          = stored_gt_len ? PTR_W'(len) : stored_lo;
  assign count         = (pick > PTR_W'(MAX_RECORD)) ? LEN_W'(MAX_RECORD)
                                                     : pick[LEN_W-1:0];
  assign free_sum      = (FREE_W+1)'(free_count) + (FREE_W+1)'(HEADER_BYTES)
                       + (FREE_W+1)'(stored_lo);
  assign free_after_pop = (stored_hi || free_sum > (FREE_W+1)'(BUFFER_BYTES))
                        ? FREE_W'(BUFFER_BYTES) : free_sum[FREE_W-1:0];
  assign need          = (FREE_W+1)'(HEADER_BYTES) + (FREE_W+1)'(len);

  always_comb begin
    stat            = '0;
    stat.op         = op;
    stat.push_open  = (push_rem != '0);
    stat.start_bad  = (len > LEN_W'(MAX_RECORD)) || ((FREE_W+1)'(free_count) < need);
    stat.empty      = (free_count == FREE_W'(BUFFER_BYTES));
    stat.hcnt_last  = (hcnt == HCNT_W'(HEADER_BYTES - 1));
    stat.count_zero = (count == '0);
    stat.cnt_last   = (cnt == LEN_W'(1));
  end

  // input transaction and stream bookkeeping
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op    <= opcode;
      len   <= record_length;
      dbyte <= data_byte;
    end
    if (cmd.load) begin
      hcnt <= '0;
    end else if (cmd.hdr_write || cmd.hdr_read) begin
      hcnt <= hcnt + HCNT_W'(1);
    end
    if (cap) begin
      hdr <= {rdata, hdr[HDR_W-1:8]};
    end
    if (cmd.calc) begin
      sp  <= rp;
      cnt <= count;
    end else if (cmd.stream_read) begin
      sp  <= sp + PTR_W'(1);
      cnt <= cnt - LEN_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rp             <= PTR_W'(BUFFER_BYTES / 2);
      wp             <= PTR_W'(BUFFER_BYTES / 2);
      free_count     <= FREE_W'(BUFFER_BYTES);
      push_rem       <= '0;
      cap            <= 1'b0;
      status_q       <= ST_OK;
      byte_valid_q   <= 1'b0;
      last_q         <= 1'b0;
      result_valid_q <= 1'b0;
    end else begin
      cap <= cmd.hdr_read;
      if (cmd.push_begin) begin
        free_count <= free_count - need[FREE_W-1:0];
        push_rem   <= len;
      end else if (cmd.flush) begin
        free_count <= FREE_W'(BUFFER_BYTES);
        rp         <= wp;
      end else if (cmd.calc) begin
        free_count <= free_after_pop;
        rp         <= rp + stored_lo;
      end else if (cmd.hdr_read) begin
        rp <= rp + PTR_W'(1);
      end
      if (we) begin
        wp <= wp + PTR_W'(1);
      end
      if (cmd.byte_write) begin
        push_rem <= push_rem - LEN_W'(1);
      end
      result_valid_q <= cmd.emit;
      status_q       <= cmd.emit ? cmd.emit_status : ST_OK;
      byte_valid_q   <= cmd.emit & cmd.emit_byte;
      last_q         <= cmd.emit & cmd.emit_last;
    end
  end

  // the popped byte comes straight from the store's read register
  assign out_byte     = byte_valid_q ? rdata : 8'd0;
  assign status       = status_q;
  assign byte_valid   = byte_valid_q;
  assign last         = last_q;
  assign result_valid = result_valid_q;
  assign free_bytes   = free_count;
  assign queue_empty  = (free_count == FREE_W'(BUFFER_BYTES));

endmodule
`default_nettype wire

>>> hw/rtl/lprf_checker.sv
// port-level assertions for the length-prefixed record fifo, bound to the top
`default_nettype none
module lprf_checker
  import lprf_pkg::*;
(
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              start,
  input wire logic              busy,
  input wire logic              result_valid,
  input wire logic [1:0]        status,
  input wire logic              byte_valid,
  input wire logic              last,
  input wire logic [FREE_W-1:0] free_bytes,
  input wire logic              queue_empty
);

  // an accepted transaction always occupies the block for the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted transaction did not raise busy");

  // a popped run streams without gaps until its last byte
  a_run_gapless: assert property (@(posedge clk) disable iff (rst)
    result_valid && !last |=> result_valid && byte_valid)
    else $error("gap inside popped run");

  // the final result of a transaction is followed by an idle result slot
  a_last_gap: assert property (@(posedge clk) disable iff (rst)
    result_valid && last |=> !result_valid)
    else $error("result right after final result");

  a_byte_ok: assert property (@(posedge clk) disable iff (rst)
    byte_valid |-> result_valid && status == ST_OK)
    else $error("popped byte outside an ok result");

  a_empty_free: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (queue_empty == (free_bytes == FREE_W'(BUFFER_BYTES))))
    else $error("empty flag disagrees with free count");

endmodule

bind length_prefixed_record_fifo lprf_checker u_lprf_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .result_valid (result_valid),
  .status       (status),
  .byte_valid   (byte_valid),
  .last         (last),
  .free_bytes   (free_bytes),
  .queue_empty  (queue_empty)
);
`default_nettype wire
